@@ hw/rtl/tked_pkg.sv @@
// Shared types, constants and decode functions for the terminal key escape decoder.
// No dependencies.
`default_nettype none

package tked_pkg;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic       KIND_CHAR    = 1'b0;
  localparam logic       KIND_SPECIAL = 1'b1;

  localparam logic [7:0] K_UP        = 8'd0;
  localparam logic [7:0] K_DOWN      = 8'd1;
  localparam logic [7:0] K_RIGHT     = 8'd2;
  localparam logic [7:0] K_LEFT      = 8'd3;
  localparam logic [7:0] K_HOME      = 8'd4;
  localparam logic [7:0] K_END       = 8'd5;
  localparam logic [7:0] K_DELETE    = 8'd6;
  localparam logic [7:0] K_PGUP      = 8'd7;
  localparam logic [7:0] K_PGDN      = 8'd8;
  localparam logic [7:0] K_F1        = 8'd9;
  localparam logic [7:0] K_F5        = 8'd10;
  localparam logic [7:0] K_ESC       = 8'd11;
  localparam logic [7:0] K_BACKSPACE = 8'd12;
  localparam logic [7:0] K_TIMEOUT   = 8'd13;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] DEL_BYTE  = 8'h7F;
  localparam logic [7:0] FINAL_MIN = 8'h40;
  localparam logic [7:0] CSI_BYTE  = 8'h5B;  // '['
  localparam logic [7:0] SS3_BYTE  = 8'h4F;  // 'O'

  localparam logic [9:0] TICK_MAX = 10'd1023;
  localparam int         HEAD_BYTES = 3;

  localparam logic [7:0] ERASE_RESET       = 8'd127;
  localparam logic [9:0] KEY_TIMEOUT_RESET = 10'd200;
  localparam logic [9:0] SEQ_TIMEOUT_RESET = 10'd50;

  localparam logic [1:0] REG_ERASE       = 2'd0;
  localparam logic [1:0] REG_KEY_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_SEQ_TIMEOUT = 2'd2;

  // Sequence length as seen by the matcher
  localparam logic [1:0] LEN_OTHER = 2'd0;
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] erase_char;
    logic [9:0] key_timeout_ticks;
    logic [9:0] seq_timeout_ticks;
  } cfg_t;

  function automatic logic [7:0] final_key(input logic [7:0] b);
    logic [7:0] k;
    case (b)
      8'h41:   k = K_UP;
      8'h42:   k = K_DOWN;
      8'h43:   k = K_RIGHT;
      8'h44:   k = K_LEFT;
      8'h48:   k = K_HOME;
      8'h46:   k = K_END;
      default: k = K_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] ss3_key(input logic [7:0] b);
    return (b == 8'h50) ? K_F1 : final_key(b);
  endfunction

  function automatic logic [7:0] decode_csi(input logic [1:0] len_sel, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] c);
    logic [7:0] k;
    k = K_ESC;
    if (len_sel == LEN_ONE) begin
      k = final_key(a);
    end else if (len_sel == LEN_TWO && b == 8'h7E) begin
      case (a)
        8'h31:   k = K_HOME;
        8'h33:   k = K_DELETE;
        8'h34:   k = K_END;
        8'h35:   k = K_PGUP;
        8'h36:   k = K_PGDN;
        default: k = K_ESC;
      endcase
    end else if (len_sel == LEN_THREE && a == 8'h31 && c == 8'h7E) begin
      if (b == 8'h31) begin
        k = K_F1;
      end else if (b == 8'h35) begin
        k = K_F5;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tked_if.sv @@
// Valid/ready channel interfaces: received bytes and ticks in, decoded keys out.
// No dependencies.
`default_nettype none

interface tked_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface tked_out_if;
  logic       valid;
  logic       ready;
  logic       key_kind;
  logic [7:0] key_code;

  modport source (output valid, output key_kind, output key_code, input ready);
  modport sink   (input valid, input key_kind, input key_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tked_core.sv @@
// Decode state machine, tick counter, CSI capture and output register.
// Depends on tked_pkg and tked_if.
`default_nettype none

module tked_core #(
  parameter int SEQ_BUFFER_BYTES = 16
) (
  input  wire             clk,
  input  wire             rst,
  input  tked_pkg::cfg_t  cfg,
  tked_in_if.sink         byte_chan,
  tked_out_if.source      key_chan
);

  localparam int LW = $clog2(SEQ_BUFFER_BYTES);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CSI,
    MODE_SS3
  } mode_t;

  mode_t          mode, mode_next;
  logic [9:0]     tick_count, tick_count_next;
  logic [LW-1:0]  seq_length, seq_length_next;
  logic [7:0]     head [tked_pkg::HEAD_BYTES];
  logic [7:0]     head_next [tked_pkg::HEAD_BYTES];
  logic           out_valid;
  logic           out_kind;
  logic [7:0]     out_code;

  logic           take;
  logic           emit;
  logic           emit_kind;
  logic [7:0]     emit_code;
  logic [9:0]     tick_inc;
  logic [9:0]     limit;
  logic [LW-1:0]  len_inc;
  logic [7:0]     b;

  function automatic logic [1:0] len_code(input logic [LW-1:0] n);
    logic [1:0] s;
    if (n == LW'(1)) begin
      s = tked_pkg::LEN_ONE;
    end else if (n == LW'(2)) begin
      s = tked_pkg::LEN_TWO;
    end else if (n == LW'(3)) begin
      s = tked_pkg::LEN_THREE;
    end else begin
      s = tked_pkg::LEN_OTHER;
    end
    return s;
  endfunction

  assign byte_chan.ready = !out_valid || key_chan.ready;
  assign take            = byte_chan.valid && byte_chan.ready;
  assign b               = byte_chan.byte_value;

  assign key_chan.valid    = out_valid;
  assign key_chan.key_kind = out_kind;
  assign key_chan.key_code = out_code;

  assign tick_inc = (tick_count == tked_pkg::TICK_MAX) ? tick_count : tick_count + 10'd1;
  assign limit    = (mode == MODE_IDLE) ? cfg.key_timeout_ticks : cfg.seq_timeout_ticks;
  assign len_inc  = seq_length + LW'(1);

  always_comb begin
    mode_next       = mode;
    tick_count_next = 10'd0;
    seq_length_next = seq_length;
    head_next       = head;
    emit            = 1'b0;
    emit_kind       = tked_pkg::KIND_SPECIAL;
    emit_code       = tked_pkg::K_ESC;
    if (byte_chan.op == tked_pkg::OP_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        emit            = 1'b1;
        tick_count_next = 10'd0;
        if (mode == MODE_IDLE) begin
          emit_code = tked_pkg::K_TIMEOUT;
        end else begin
          if (mode == MODE_CSI) begin
            emit_code = tked_pkg::decode_csi(len_code(seq_length), head[0], head[1], head[2]);
          end
          mode_next       = MODE_IDLE;
          seq_length_next = '0;
        end
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          if (b == cfg.erase_char || b == tked_pkg::DEL_BYTE) begin
            emit      = 1'b1;
            emit_code = tked_pkg::K_BACKSPACE;
          end else if (b == tked_pkg::ESC_BYTE) begin
            mode_next = MODE_ESC;
          end else begin
            emit      = 1'b1;
            emit_kind = tked_pkg::KIND_CHAR;
            emit_code = b;
          end
        end
        MODE_ESC: begin
          if (b == tked_pkg::CSI_BYTE) begin
            mode_next       = MODE_CSI;
            seq_length_next = '0;
          end else if (b == tked_pkg::SS3_BYTE) begin
            mode_next = MODE_SS3;
          end else begin
            emit            = 1'b1;
            mode_next       = MODE_IDLE;
            seq_length_next = '0;
          end
        end
        MODE_CSI: begin
          if (seq_length < LW'(tked_pkg::HEAD_BYTES)) begin
            head_next[seq_length[1:0]] = b;
          end
          seq_length_next = len_inc;
          if (b >= tked_pkg::FINAL_MIN || len_inc >= LW'(SEQ_BUFFER_BYTES - 1)) begin
            emit            = 1'b1;
            emit_code       = tked_pkg::decode_csi(len_code(len_inc), head_next[0],
                                                   head_next[1], head_next[2]);
            mode_next       = MODE_IDLE;
            seq_length_next = '0;
          end
        end
        MODE_SS3: begin
          emit            = 1'b1;
          emit_code       = tked_pkg::ss3_key(b);
          mode_next       = MODE_IDLE;
          seq_length_next = '0;
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      tick_count <= 10'd0;
      seq_length <= '0;
      out_valid  <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      tick_count <= tick_count_next;
      seq_length <= seq_length_next;
      head       <= head_next;
      out_valid  <= emit;
      if (emit) begin
        out_kind <= emit_kind;
        out_code <= emit_code;
      end
    end else if (key_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_idle_no_length: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> seq_length == '0)
    else $error("sequence length nonzero while idle");

  a_csi_length_bound: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_CSI |-> seq_length < LW'(SEQ_BUFFER_BYTES - 1))
    else $error("sequence length past buffer end");

  a_idle_byte_emits: assert property (@(posedge clk) disable iff (rst)
    (take && mode == MODE_IDLE && byte_chan.op == tked_pkg::OP_BYTE &&
     b != tked_pkg::ESC_BYTE) |=> out_valid)
    else $error("idle byte produced no key beat");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> byte_chan.ready)
    else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/terminal_key_escape_decoder.sv @@
// Terminal key escape decoder top level: APB configuration registers and the decode core.
// Depends on tked_pkg, tked_if and tked_core.
// Takes one byte or tick beat per cycle on byte_chan; a key beat appears on key_chan in the
// cycle after the input beat that causes it. The single output register sets the rate:
// byte_chan.ready is high whenever that register is empty or is being taken in the same
// cycle, so with key_chan.ready held high the block sustains one input beat per clock.
// Ticks and bytes that complete no key produce no output beat.
`default_nettype none

module terminal_key_escape_decoder #(
  parameter int SEQ_BUFFER_BYTES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tked_in_if.sink     byte_chan,
  tked_out_if.source  key_chan
);

  tked_pkg::cfg_t cfg;
  logic [1:0]     reg_index;
  logic           wr;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr        = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.erase_char        <= tked_pkg::ERASE_RESET;
      cfg.key_timeout_ticks <= tked_pkg::KEY_TIMEOUT_RESET;
      cfg.seq_timeout_ticks <= tked_pkg::SEQ_TIMEOUT_RESET;
    end else if (wr) begin
      unique case (reg_index)
        tked_pkg::REG_ERASE:       cfg.erase_char        <= pwdata[7:0];
        tked_pkg::REG_KEY_TIMEOUT: cfg.key_timeout_ticks <= pwdata[9:0];
        tked_pkg::REG_SEQ_TIMEOUT: cfg.seq_timeout_ticks <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      tked_pkg::REG_ERASE:       prdata = {24'd0, cfg.erase_char};
      tked_pkg::REG_KEY_TIMEOUT: prdata = {22'd0, cfg.key_timeout_ticks};
      tked_pkg::REG_SEQ_TIMEOUT: prdata = {22'd0, cfg.seq_timeout_ticks};
      default:                   prdata = 32'd0;
    endcase
  end

  tked_core #(
    .SEQ_BUFFER_BYTES(SEQ_BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .byte_chan (byte_chan),
    .key_chan  (key_chan)
  );

endmodule

`default_nettype wire
